[src/piecewise_linear_table_interp_assert.svh]
// assertion macros for the interpolator datapath module
// the asserting module must have ports named clock and reset
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH

// expression holds on every clock edge outside reset
`define PLTI_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent holds at the same edge as the antecedent
`define PLTI_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds at the edge after the antecedent
`define PLTI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/plti_pkg.sv]
// ----------------------------------------------------------------------------
// plti_pkg
// Types, codes and defaults shared by the breakpoint table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package plti_pkg;

   // default table depth
   localparam int MAX_POINTS_DEF = 64;

   // field widths
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int SEG_W    = 6;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUP  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FEW  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SAT  = 3'd4;

   // divider: 64-bit dividend, one quotient bit per cycle
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = 7;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] x_value;
      logic signed [VALUE_W-1:0] y_value;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic [STATUS_W-1:0]       status;
      logic [SEG_W-1:0]          segment;
   } rsp_word_type;

   // datapath commands
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,
      OP_BS_RD,
      OP_BS_CMP,
      OP_DUP_RD,
      OP_DUP_CMP,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_INSERT,
      OP_SEG,
      OP_RD_LO,
      OP_RD_HI,
      OP_CAP_HI,
      OP_MUL_A,
      OP_MUL_B,
      OP_SUM,
      OP_DIV_SETUP,
      OP_DIV_STEP,
      OP_DONE_OK,
      OP_DONE_CLEAR,
      OP_DONE_DUP,
      OP_DONE_FULL,
      OP_DONE_FEW,
      OP_DONE_QUERY
   } dp_op_type;

   // datapath status back to the controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              bs_done;
      logic              dup_hit;
      logic              full;
      logic              few;
      logic              shift_done;
      logic              div_done;
      logic              rsp_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

[src/piecewise_linear_table_interp.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp
// Sorted breakpoint table with linear interpolation and extrapolation.
// ----------------------------------------------------------------------------
// One request word is worked on at a time; a finished result word sits in an
// output register, so the next request is taken while it waits. An add runs
// a lower-bound search, then moves the stored points above the new one up,
// one at a time through the single memory port, before it writes the new one.
// A query runs the same search and then the divider, which produces one
// quotient bit per cycle over a 64-bit dividend. A result word still waiting
// in the output register holds the next one back.
`default_nettype none

module piecewise_linear_table_interp
   import plti_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   dp_op_type   op;
   dp_stat_type stat;

   plti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .op        (op)
   );

   plti_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .stat      (stat),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

[src/plti_ram.sv]
// ----------------------------------------------------------------------------
// plti_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/plti_ctrl.sv]
// ----------------------------------------------------------------------------
// plti_ctrl
// Sequencer for clear, add and query; issues one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_ctrl
   import plti_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dp_stat_type stat,
   output dp_op_type        op
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_BS_RD,
      S_BS_CMP,
      S_DUP_RD,
      S_DUP_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_INSERT,
      S_SEG,
      S_RD_LO,
      S_RD_HI,
      S_CAP_HI,
      S_MUL_A,
      S_MUL_B,
      S_SUM,
      S_DIV_SETUP,
      S_DIV,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   dp_op_type done_code_ff, done_code_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and command decode
   always_comb begin
      state_in     = state_ff;
      done_code_in = done_code_ff;
      op           = OP_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.kind)
               KIND_CLEAR: begin
                  done_code_in = OP_DONE_CLEAR;
                  state_in     = S_DONE;
               end
               KIND_ADD: state_in = S_BS_RD;
               KIND_QUERY: begin
                  if (stat.few) begin
                     done_code_in = OP_DONE_FEW;
                     state_in     = S_DONE;
                  end else begin
                     state_in = S_BS_RD;
                  end
               end
               default: begin
                  done_code_in = OP_DONE_OK;
                  state_in     = S_DONE;
               end
            endcase
         end
         // lower-bound search over the stored abscissas
         S_BS_RD: begin
            if (stat.bs_done) begin
               state_in = (stat.kind == KIND_ADD) ? S_DUP_RD : S_SEG;
            end else begin
               op       = OP_BS_RD;
               state_in = S_BS_CMP;
            end
         end
         S_BS_CMP: begin
            op       = OP_BS_CMP;
            state_in = S_BS_RD;
         end
         // add: duplicate check, full check, then make room
         S_DUP_RD: begin
            op       = OP_DUP_RD;
            state_in = S_DUP_CMP;
         end
         S_DUP_CMP: begin
            op = OP_DUP_CMP;
            if (stat.dup_hit) begin
               done_code_in = OP_DONE_DUP;
               state_in     = S_DONE;
            end else if (stat.full) begin
               done_code_in = OP_DONE_FULL;
               state_in     = S_DONE;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_done) begin
               state_in = S_INSERT;
            end else begin
               op       = OP_SHIFT_RD;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            op       = OP_SHIFT_WR;
            state_in = S_SHIFT_RD;
         end
         S_INSERT: begin
            op           = OP_INSERT;
            done_code_in = OP_DONE_OK;
            state_in     = S_DONE;
         end
         // query: fetch the segment, multiply, divide
         S_SEG: begin
            op       = OP_SEG;
            state_in = S_RD_LO;
         end
         S_RD_LO: begin
            op       = OP_RD_LO;
            state_in = S_RD_HI;
         end
         S_RD_HI: begin
            op       = OP_RD_HI;
            state_in = S_CAP_HI;
         end
         S_CAP_HI: begin
            op       = OP_CAP_HI;
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            op       = OP_MUL_A;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            op       = OP_MUL_B;
            state_in = S_SUM;
         end
         S_SUM: begin
            op       = OP_SUM;
            state_in = S_DIV_SETUP;
         end
         S_DIV_SETUP: begin
            op       = OP_DIV_SETUP;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (stat.div_done) begin
               done_code_in = OP_DONE_QUERY;
               state_in     = S_DONE;
            end else begin
               op = OP_DIV_STEP;
            end
         end
         // hand the word to the output register once it is free
         S_DONE: begin
            if (!stat.rsp_busy) begin
               op       = done_code_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         done_code_ff <= OP_DONE_OK;
      end else begin
         state_ff     <= state_in;
         done_code_ff <= done_code_in;
      end
   end

endmodule

`default_nettype wire

[src/plti_dp.sv]
// ----------------------------------------------------------------------------
// plti_dp
// Breakpoint memories, search pointers, multiplier, divider and result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "piecewise_linear_table_interp_assert.svh"

module plti_dp
   import plti_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dp_op_type    op,
   output dp_stat_type       stat,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   // request and table pointers
   logic [KIND_W-1:0]         kind_ff;
   logic signed [VALUE_W-1:0] xq_ff, yq_ff;
   logic [CW-1:0]             count_ff, lo_ff, hi_ff, idx_ff;
   logic [CW-1:0]             mid;

   // segment end points and arithmetic
   logic signed [VALUE_W-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic signed [VALUE_W:0]   mul_l;
   logic signed [VALUE_W-1:0] mul_r;
   logic signed [2*VALUE_W:0] prod, a_ff, b_ff;
   logic signed [2*VALUE_W+1:0] sum_ff;
   logic [2*VALUE_W+1:0]      sum_abs;
   logic                      neg_ff;
   logic [DIV_W-1:0]          dvd_ff;
   logic [VALUE_W-1:0]        rem_ff;
   logic [VALUE_W:0]          rem_sh, rem_sub;
   logic [VALUE_W-1:0]        den_ff;
   logic [DIV_CNT_W-1:0]      div_cnt_ff;
   logic                      sat_pos, sat_neg;
   logic signed [VALUE_W-1:0] quot_val;
   logic [CW+SEG_W-1:0]       seg_ext;

   // memory ports
   logic                      wr_en;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic [VALUE_W-1:0]        wr_x, wr_y, rd_x_raw, rd_y_raw;
   logic signed [VALUE_W-1:0] rd_x, rd_y;

   // output register
   logic                      rsp_valid_ff;
   rsp_word_type              rsp_ff, rsp_in;

   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_x = $signed(rd_x_raw);
   assign rd_y = $signed(rd_y_raw);

   // read address select
   always_comb begin
      case (op)
         OP_BS_RD:    rd_addr = mid[AW-1:0];
         OP_DUP_RD:   rd_addr = lo_ff[AW-1:0];
         OP_SHIFT_RD: rd_addr = AW'(idx_ff - CW'(1));
         OP_RD_LO:    rd_addr = AW'(idx_ff - CW'(1));
         OP_RD_HI:    rd_addr = idx_ff[AW-1:0];
         default:     rd_addr = '0;
      endcase
   end

   // write port: shift an entry up or insert the new point
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_x    = rd_x_raw;
      wr_y    = rd_y_raw;
      case (op)
         OP_SHIFT_WR: wr_en = 1'b1;
         OP_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff[AW-1:0];
            wr_x    = xq_ff;
            wr_y    = yq_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   plti_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_POINTS)) u_ram_x (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_x),
      .rd_addr (rd_addr),
      .rd_data (rd_x_raw)
   );

   plti_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_POINTS)) u_ram_y (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_y),
      .rd_addr (rd_addr),
      .rd_data (rd_y_raw)
   );

   // shared multiplier operands
   always_comb begin
      if (op == OP_MUL_A) begin
         mul_l = {x1_ff[VALUE_W-1], x1_ff} - {xq_ff[VALUE_W-1], xq_ff};
         mul_r = y0_ff;
      end else begin
         mul_l = {xq_ff[VALUE_W-1], xq_ff} - {x0_ff[VALUE_W-1], x0_ff};
         mul_r = y1_ff;
      end
   end

   assign prod    = mul_l * mul_r;
   assign sum_abs = sum_ff[2*VALUE_W+1] ? -sum_ff : sum_ff;

   // restoring divider step
   assign rem_sh  = {rem_ff, dvd_ff[DIV_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   // saturation of the quotient
   assign sat_pos  = !neg_ff && (dvd_ff > DIV_W'(64'h7FFF_FFFF));
   assign sat_neg  = neg_ff && (dvd_ff > DIV_W'(64'h8000_0000));
   assign quot_val = neg_ff ? -$signed(dvd_ff[VALUE_W-1:0]) : $signed(dvd_ff[VALUE_W-1:0]);
   assign seg_ext  = {{SEG_W{1'b0}}, idx_ff};

   // status back to the controller
   assign stat.kind       = kind_ff;
   assign stat.bs_done    = (lo_ff >= hi_ff);
   assign stat.dup_hit    = (lo_ff < count_ff) && (rd_x == xq_ff);
   assign stat.full       = (count_ff == CW'(MAX_POINTS));
   assign stat.few        = (count_ff < CW'(2));
   assign stat.shift_done = (idx_ff == lo_ff);
   assign stat.div_done   = (div_cnt_ff == DIV_CNT_W'(DIV_W));
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // datapath registers
   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            kind_ff <= req_word.kind;
            xq_ff   <= req_word.x_value;
            yq_ff   <= req_word.y_value;
            lo_ff   <= '0;
            hi_ff   <= count_ff;
         end
         OP_BS_CMP: begin
            if (rd_x < xq_ff) begin
               lo_ff <= mid + CW'(1);
            end else begin
               hi_ff <= mid;
            end
         end
         OP_DUP_CMP:  idx_ff <= count_ff;
         OP_SHIFT_WR: idx_ff <= idx_ff - CW'(1);
         OP_SEG: begin
            if (lo_ff == '0) begin
               idx_ff <= CW'(1);
            end else if (lo_ff == count_ff) begin
               idx_ff <= count_ff - CW'(1);
            end else begin
               idx_ff <= lo_ff;
            end
         end
         OP_RD_HI: begin
            x0_ff <= rd_x;
            y0_ff <= rd_y;
         end
         OP_CAP_HI: begin
            x1_ff <= rd_x;
            y1_ff <= rd_y;
         end
         OP_MUL_A: a_ff <= prod;
         OP_MUL_B: b_ff <= prod;
         OP_SUM:   sum_ff <= {a_ff[2*VALUE_W], a_ff} + {b_ff[2*VALUE_W], b_ff};
         OP_DIV_SETUP: begin
            neg_ff     <= sum_ff[2*VALUE_W+1];
            dvd_ff     <= sum_abs[DIV_W-1:0];
            rem_ff     <= '0;
            den_ff     <= VALUE_W'(x1_ff - x0_ff);
            div_cnt_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= rem_sub[VALUE_W-1:0];
               dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[VALUE_W-1:0];
               dvd_ff <= {dvd_ff[DIV_W-2:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   // stored point count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (op == OP_DONE_CLEAR) begin
         count_ff <= '0;
      end else if (op == OP_INSERT) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // next result word
   always_comb begin
      rsp_in = rsp_ff;
      case (op)
         OP_DONE_OK, OP_DONE_CLEAR: begin
            rsp_in        = '0;
            rsp_in.status = ST_OK;
         end
         OP_DONE_DUP: begin
            rsp_in        = '0;
            rsp_in.status = ST_DUP;
         end
         OP_DONE_FULL: begin
            rsp_in        = '0;
            rsp_in.status = ST_FULL;
         end
         OP_DONE_FEW: begin
            rsp_in        = '0;
            rsp_in.status = ST_FEW;
         end
         OP_DONE_QUERY: begin
            rsp_in.segment = seg_ext[SEG_W-1:0];
            if (sat_pos) begin
               rsp_in.result_value = 32'sh7FFF_FFFF;
               rsp_in.status       = ST_SAT;
            end else if (sat_neg) begin
               rsp_in.result_value = 32'sh8000_0000;
               rsp_in.status       = ST_SAT;
            end else begin
               rsp_in.result_value = quot_val;
               rsp_in.status       = ST_OK;
            end
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   // result word register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // result word valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (op == OP_DONE_OK || op == OP_DONE_CLEAR || op == OP_DONE_DUP ||
                   op == OP_DONE_FULL || op == OP_DONE_FEW || op == OP_DONE_QUERY) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // checks
   `PLTI_ASSERT_ALWAYS(a_count_range, count_ff <= CW'(MAX_POINTS),
      "point count beyond table depth")
   `PLTI_ASSERT_NEXT(a_insert_count, op == OP_INSERT,
      count_ff == $past(count_ff) + CW'(1), "insert did not bump point count")
   `PLTI_ASSERT_NEXT(a_search_order, op == OP_BS_CMP, lo_ff <= hi_ff,
      "search bounds crossed")
   `PLTI_ASSERT_SAME(a_no_overwrite, op == OP_DONE_OK || op == OP_DONE_CLEAR ||
      op == OP_DONE_DUP || op == OP_DONE_FULL || op == OP_DONE_FEW ||
      op == OP_DONE_QUERY, !(rsp_valid_ff && !rsp_ready),
      "result word overwritten before taken")

endmodule

`default_nettype wire

[test/piecewise_linear_table_interp_tb.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_tb
// Drives clear, add and query words into the breakpoint table interpolator
// and compares every result word with a local model of the sorted table,
// the segment hint and the saturating interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interp_tb;
   import plti_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = MAX_POINTS_DEF;
   localparam int CYCLE_LIMIT = 900000;
   localparam int RANDOM_WORDS = 430;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_word;

   // model state
   logic signed [VALUE_W-1:0] tbl_x [TABLE_DEPTH];
   logic signed [VALUE_W-1:0] tbl_y [TABLE_DEPTH];
   int unsigned tbl_count;
   int unsigned tbl_hint;

   rsp_word_type pending_rsp [$];
   int error_count;
   int unsigned cycle_count;

   // directed stimulus table, with optional typed-in result
   typedef struct {
      req_word_type word;
      bit           fixed;
      rsp_word_type rsp;
   } dir_row_type;

   piecewise_linear_table_interp u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // segment lookup with last-segment hint, then lower-bound search
   function automatic int unsigned locate_segment(logic signed [VALUE_W-1:0] xq);
      int unsigned n, c, lo, hi, mid;
      n = tbl_count;
      c = tbl_hint;
      if (xq <= tbl_x[0]) return 0;
      if (xq > tbl_x[n-1]) return n;
      if (c >= 1 && c <= n - 1) begin
         if (xq > tbl_x[c-1] && xq <= tbl_x[c]) return c;
         if (c > 1 && n > 2 && xq > tbl_x[c-2] && xq <= tbl_x[c-1]) begin
            tbl_hint = c - 1;
            return c - 1;
         end
         if (c < n - 1 && n > 2 && xq > tbl_x[c] && xq <= tbl_x[c+1]) begin
            tbl_hint = c + 1;
            return c + 1;
         end
      end
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_x[mid] < xq) lo = mid + 1;
         else hi = mid;
      end
      tbl_hint = lo;
      return lo;
   endfunction

   // advance the table model by one word and return its result
   function automatic rsp_word_type interp_table_step(req_word_type w);
      rsp_word_type r;
      int unsigned pos, k;
      bit dup;
      logic signed [127:0] x0, x1, y0, y1, xq, num, q;
      r = '0;
      case (w.kind)
         KIND_CLEAR: begin
            tbl_count = 0;
            tbl_hint = 1;
         end
         KIND_ADD: begin
            pos = 0;
            dup = 0;
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_x[i] == w.x_value) dup = 1;
               if (tbl_x[i] < w.x_value) pos = i + 1;
            end
            if (dup) r.status = ST_DUP;
            else if (tbl_count >= TABLE_DEPTH) r.status = ST_FULL;
            else begin
               for (int i = tbl_count; i > pos; i--) begin
                  tbl_x[i] = tbl_x[i-1];
                  tbl_y[i] = tbl_y[i-1];
               end
               tbl_x[pos] = w.x_value;
               tbl_y[pos] = w.y_value;
               tbl_count++;
            end
         end
         KIND_QUERY: begin
            if (tbl_count < 2) r.status = ST_FEW;
            else begin
               k = locate_segment(w.x_value);
               if (k == 0) k = 1;
               else if (k == tbl_count) k = tbl_count - 1;
               r.segment = k[SEG_W-1:0];
               x0 = tbl_x[k-1];
               x1 = tbl_x[k];
               y0 = tbl_y[k-1];
               y1 = tbl_y[k];
               xq = w.x_value;
               num = (x1 - xq) * y0 + (xq - x0) * y1;
               q = num / (x1 - x0);
               if (q > 128'sh7FFFFFFF) begin
                  r.result_value = 32'h7FFFFFFF;
                  r.status = ST_SAT;
               end else if (q < -128'sh80000000) begin
                  r.result_value = 32'h80000000;
                  r.status = ST_SAT;
               end else r.result_value = q[VALUE_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // random x drawn from a few regimes so queries hit all segments
   function automatic logic [VALUE_W-1:0] pick_x();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 40) << 16;
         2: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return $urandom_range(0, 1) ? 32'h7FFFFFF0 + $urandom_range(0, 15)
                                               : 32'h80000000 + $urandom_range(0, 15);
      endcase
   endfunction

   // hand one word to the block, record the expected result
   task automatic send_word(req_word_type w, bit fixed, rsp_word_type fixed_rsp);
      rsp_word_type r;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = interp_table_step(w);
      if (fixed && r != fixed_rsp) begin
         $display("%0t model disagrees with table row: expected %h actual %h",
                  $time, fixed_rsp, r);
         error_count++;
      end
      pending_rsp.insert(pending_rsp.size(), fixed ? fixed_rsp : r);
   endtask

   task automatic idle_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else case ((cycle_count / 200) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (cycle_count % 7 < 3);
      endcase
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result word: expected none actual %h", $time, rsp_word);
            error_count++;
         end else begin
            if (rsp_word.result_value !== pending_rsp[0].result_value) begin
               $display("%0t result_value mismatch: expected %h actual %h", $time,
                        pending_rsp[0].result_value, rsp_word.result_value);
               error_count++;
            end
            if (rsp_word.status !== pending_rsp[0].status) begin
               $display("%0t status mismatch: expected %0d actual %0d", $time,
                        pending_rsp[0].status, rsp_word.status);
               error_count++;
            end
            if (rsp_word.segment !== pending_rsp[0].segment) begin
               $display("%0t segment mismatch: expected %0d actual %0d", $time,
                        pending_rsp[0].segment, rsp_word.segment);
               error_count++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL piecewise_linear_table_interp");
         $finish;
      end
   end

   // stimulus
   initial begin
      dir_row_type dir_rows [$];
      dir_row_type row;
      req_word_type w;
      int burst;
      int unsigned sent;
      error_count = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_x[i] = '0;
         tbl_y[i] = '0;
      end
      tbl_count = 0;
      tbl_hint = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: {kind, x, y}, fixed flag, {result, status, segment}
      dir_rows = '{
         '{'{KIND_QUERY, 32'sd0, 32'sd0}, 1, '{32'sd0, ST_FEW, 6'd0}},
         '{'{KIND_ADD, 32'sh00010000, 32'sh00020000}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sd0, 32'sd0}, 1, '{32'sd0, ST_FEW, 6'd0}},
         '{'{KIND_ADD, 32'sh00010000, 32'sd5}, 1, '{32'sd0, ST_DUP, 6'd0}},
         '{'{KIND_ADD, 32'sh00030000, 32'sh00060000}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sh00020000, 32'sd0}, 1, '{32'sh00040000, ST_OK, 6'd1}},
         '{'{KIND_QUERY, 32'sh00010000, 32'sd0}, 1, '{32'sh00020000, ST_OK, 6'd1}},
         '{'{KIND_QUERY, 32'sh80000000, 32'sd0}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sh7FFFFFFF, 32'sd0}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_ADD, 32'sh00000000, 32'sh80000000}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_ADD, 32'sh80000000, 32'sh7FFFFFFF}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sh00008000, 32'sd0}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sh00028000, 32'sd0}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sh40000000, 32'sd0}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'shC0000000, 32'sd0}, 0, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_UNUSED, 32'shFFFFFFFF, 32'shFFFFFFFF}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_CLEAR, 32'sd0, 32'sd0}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_ADD, 32'sd0, 32'sd0}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_ADD, 32'sd1, 32'sh7FFFFFFF}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sh7FFFFFFF, 32'sd0}, 1, '{32'sh7FFFFFFF, ST_SAT, 6'd1}},
         '{'{KIND_CLEAR, 32'sd0, 32'sd0}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_ADD, 32'sd0, 32'sd0}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_ADD, 32'sd1, 32'sh80000000}, 1, '{32'sd0, ST_OK, 6'd0}},
         '{'{KIND_QUERY, 32'sh7FFFFFFF, 32'sd0}, 1, '{32'sh80000000, ST_SAT, 6'd1}}
      };
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_word(row.word, row.fixed, row.rsp);
         if ($urandom_range(0, 2) == 0) idle_gap();
      end

      // fill the table to capacity, then overflow it
      w.kind = KIND_CLEAR; w.x_value = '0; w.y_value = '0;
      send_word(w, 0, '0);
      for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
         w.kind = KIND_ADD;
         w.x_value = (i * 37 % (TABLE_DEPTH + 3)) << 12;
         w.y_value = $urandom();
         send_word(w, 0, '0);
      end

      // random part: bursts of sessions, mostly well-formed table builds
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            case ($urandom_range(0, 19))
               0: w.kind = KIND_CLEAR;
               1: w.kind = KIND_UNUSED;
               2, 3, 4, 5, 6, 7: w.kind = KIND_ADD;
               default: w.kind = KIND_QUERY;
            endcase
            if (w.kind == KIND_ADD && tbl_count > 12 && $urandom_range(0, 3) != 0)
               w.kind = KIND_QUERY;
            w.x_value = pick_x();
            if (w.kind == KIND_ADD && tbl_count > 0 && $urandom_range(0, 9) == 0)
               w.x_value = tbl_x[$urandom_range(0, tbl_count - 1)];
            if (w.kind == KIND_QUERY && tbl_count > 0 && $urandom_range(0, 3) == 0)
               w.x_value = tbl_x[$urandom_range(0, tbl_count - 1)];
            w.y_value = ($urandom_range(0, 3) == 0) ? $urandom()
                        : 32'($signed($urandom_range(0, 200000)) - 100000);
            send_word(w, 0, '0);
            if (w.kind != KIND_UNUSED) sent++;
         end
         if (sent > RANDOM_WORDS / 2 && sent < RANDOM_WORDS / 2 + 13) begin
            // drain fully before going on
            req_valid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end else if ($urandom_range(0, 3) != 0) idle_gap();
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS piecewise_linear_table_interp");
      end else begin
         $display("FAIL piecewise_linear_table_interp");
      end
      $finish;
   end

endmodule

`default_nettype wire
